// ===== rtl/lcs_dp_traceback_top_macros.svh =====
// ----------------------------------------------------------------------------
// lcs dp traceback assertion macros
// shared assertion forms used by the rtl modules
// ----------------------------------------------------------------------------
`ifndef LCS_DP_TRACEBACK_TOP_MACROS_SVH
`define LCS_DP_TRACEBACK_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define LCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define LCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcs package
// shared types and codes of the lcs dp traceback block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lcs_pkg;

    localparam logic [1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;
    localparam logic [1:0] ACT_NOP     = 2'd3;

    localparam logic [1:0] DIR_DIAG = 2'd1;
    localparam logic [1:0] DIR_UP   = 2'd2;
    localparam logic [1:0] DIR_LEFT = 2'd3;

    // command passed from front to back
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] symbol;
    } lcs_cmd_t;

endpackage

// ===== rtl/lcs_front.sv =====
// ----------------------------------------------------------------------------
// lcs front
// accepts input beats, drops nop actions, queues commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lcs_front
    import lcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  lcs_cmd_t   in_cmd,
    output logic       q_valid,
    input  logic       q_ready,
    output lcs_cmd_t   q_cmd
);
    `include "lcs_dp_traceback_top_macros.svh"

    lcs_cmd_t   mem_reg [4];
    logic [1:0] wr_reg;
    logic [1:0] rd_reg;
    logic [2:0] cnt_reg;
    logic       push;
    logic       pop;
    logic       keep;

    assign in_ready = (cnt_reg != 3'd4);
    assign keep     = (in_cmd.action != ACT_NOP);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (cnt_reg != 3'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {2'b0, push} - {2'b0, pop};
        end
    end

    `LCS_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= 3'd4, "queue count out of range")
    `LCS_ASSERT_NEXT(a_push_grows, clk, rst_n, push && !pop, cnt_reg == $past(cnt_reg) + 3'd1,
        "queue count not advanced")
    `LCS_ASSERT_IMP(a_no_drop_full, clk, rst_n, cnt_reg == 3'd4, !in_ready, "ready while full")
endmodule

// ===== rtl/lcs_back.sv =====
// ----------------------------------------------------------------------------
// lcs back
// stores sequences, fills score table, traces back, emits result beats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lcs_back
    import lcs_pkg::*;
#(
    parameter int MAX_A = 32,
    parameter int MAX_B = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    output logic     q_ready,
    input  lcs_cmd_t q_cmd,
    output logic     o_valid,
    input  logic     o_ready,
    output logic [7:0] o_symbol,
    output logic [5:0] o_length,
    output logic     o_last,
    output logic     o_empty
);
    `include "lcs_dp_traceback_top_macros.svh"

    localparam int AW  = (MAX_A > 1) ? $clog2(MAX_A) : 1;
    localparam int BW  = (MAX_B > 1) ? $clog2(MAX_B) : 1;
    localparam int ACW = $clog2(MAX_A + 1);
    localparam int BCW = $clog2(MAX_B + 1);
    localparam int MINAB = (MAX_A < MAX_B) ? MAX_A : MAX_B;
    localparam int PW  = (MINAB > 1) ? $clog2(MINAB) : 1;
    localparam int PCW = $clog2(MINAB + 1);
    localparam int SW  = PCW;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FILL  = 3'd1;
    localparam logic [2:0] ST_FWAIT = 3'd2;
    localparam logic [2:0] ST_TRACE = 3'd3;
    localparam logic [2:0] ST_TWAIT = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [7:0] seq_a_mem [MAX_A];
    logic [7:0] seq_b_mem [MAX_B];
    logic [1:0] dir_mem   [MAX_A * MAX_B];
    logic [7:0] path_mem  [MINAB];
    // one score row for columns 1..count_b, overwritten in place row by row
    logic [SW-1:0] row_mem [MAX_B];

    logic [2:0]     state_reg;
    logic [ACW-1:0] count_a_reg;
    logic [BCW-1:0] count_b_reg;
    logic [ACW-1:0] i_reg;
    logic [BCW-1:0] j_reg;
    logic [7:0]     a_sym_reg;
    logic [PCW-1:0] pos_reg;
    logic [SW-1:0]  len_reg;
    logic [PCW-1:0] k_reg;
    logic [1:0]     dir_rd_reg;
    logic [7:0]     seqa_rd_reg;
    logic [7:0]     path_rd_reg;
    logic [SW-1:0]  row_rd_reg;
    logic [7:0]     b_rd_reg;
    logic [SW-1:0]  left_reg;
    logic [SW-1:0]  diag_reg;
    logic           o_valid_reg;
    logic [7:0]     o_symbol_reg;
    logic [5:0]     o_length_reg;
    logic           o_last_reg;
    logic           o_empty_reg;

    logic [SW-1:0] up_s, left_s, diag_s, new_s;
    logic [1:0] new_d;
    logic       fill_we;
    logic [AW+BW-1:0] fill_addr, trace_addr;
    logic       out_free;
    logic       emit_go;

    assign out_free = !o_valid_reg || o_ready;
    assign q_ready  = (state_reg == ST_IDLE);
    assign emit_go  = (state_reg == ST_EMIT) && out_free && (i_reg == '1);

    // one cell per cycle along row i, column j (1-based); column j is read
    // in the cycle before it is used, the diagonal is the up score of the previous cell
    assign up_s   = (i_reg == ACW'(1)) ? '0 : row_rd_reg;
    assign left_s = left_reg;
    assign diag_s = diag_reg;
    always_comb
    begin
        if (a_sym_reg == b_rd_reg)
        begin
            new_s = diag_s + SW'(1);
            new_d = DIR_DIAG;
        end
        else if (up_s >= left_s)
        begin
            new_s = up_s;
            new_d = DIR_UP;
        end
        else
        begin
            new_s = left_s;
            new_d = DIR_LEFT;
        end
    end
    assign fill_we   = (state_reg == ST_FILL) && (j_reg != '0);
    assign fill_addr = AW'(i_reg - ACW'(1)) * (AW+BW)'(MAX_B) + (AW+BW)'(j_reg - BCW'(1));
    assign trace_addr = AW'(i_reg - ACW'(1)) * (AW+BW)'(MAX_B) + (AW+BW)'(j_reg - BCW'(1));

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready && q_cmd.action == ACT_LOAD_A && count_a_reg < ACW'(MAX_A))
        begin
            seq_a_mem[count_a_reg[AW-1:0]] <= q_cmd.symbol;
        end
        if (q_valid && q_ready && q_cmd.action == ACT_LOAD_B && count_b_reg < BCW'(MAX_B))
        begin
            seq_b_mem[count_b_reg[BW-1:0]] <= q_cmd.symbol;
        end
        if (fill_we)
        begin
            dir_mem[fill_addr] <= new_d;
        end
        dir_rd_reg  <= dir_mem[trace_addr];
        seqa_rd_reg <= seq_a_mem[AW'(i_reg - ACW'(1))];
        if (state_reg == ST_TRACE && dir_rd_reg == DIR_DIAG)
        begin
            path_mem[PW'(pos_reg - PCW'(1))] <= seqa_rd_reg;
        end
        path_rd_reg <= path_mem[k_reg[PW-1:0]];
        // fetch column j + 1 for the next cell
        if (state_reg == ST_FILL && j_reg < count_b_reg)
        begin
            row_rd_reg <= row_mem[BW'(j_reg)];
            b_rd_reg   <= seq_b_mem[BW'(j_reg)];
        end
        if (fill_we)
        begin
            row_mem[BW'(j_reg - BCW'(1))] <= new_s;
            left_reg <= new_s;
            diag_reg <= up_s;
        end
        else if (state_reg == ST_FILL)
        begin
            left_reg <= '0;
            diag_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_a_reg <= '0;
            count_b_reg <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            a_sym_reg   <= '0;
            pos_reg     <= '0;
            len_reg     <= '0;
            k_reg       <= '0;
            o_valid_reg <= 1'b0;
            o_symbol_reg <= '0;
            o_length_reg <= '0;
            o_last_reg  <= 1'b0;
            o_empty_reg <= 1'b0;
        end
        else
        begin
            if (o_valid_reg && o_ready && !emit_go)
            begin
                o_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        case (q_cmd.action)
                            ACT_LOAD_A:
                            begin
                                if (count_a_reg < ACW'(MAX_A))
                                begin
                                    count_a_reg <= count_a_reg + ACW'(1);
                                end
                            end
                            ACT_LOAD_B:
                            begin
                                if (count_b_reg < BCW'(MAX_B))
                                begin
                                    count_b_reg <= count_b_reg + BCW'(1);
                                end
                            end
                            ACT_COMPUTE:
                            begin
                                len_reg <= '0;
                                if (count_a_reg == '0 || count_b_reg == '0)
                                begin
                                    state_reg <= ST_EMIT;
                                    k_reg     <= '0;
                                end
                                else
                                begin
                                    i_reg     <= ACW'(1);
                                    j_reg     <= '0;
                                    a_sym_reg <= seq_a_mem[0];
                                    state_reg <= ST_FILL;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_FILL:
                begin
                    if (j_reg == count_b_reg)
                    begin
                        state_reg <= ST_FWAIT;
                        if (i_reg == count_a_reg)
                        begin
                            len_reg <= new_s;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + BCW'(1);
                    end
                end
                ST_FWAIT:
                begin
                    if (i_reg == count_a_reg)
                    begin
                        j_reg     <= count_b_reg;
                        pos_reg   <= PCW'(len_reg);
                        state_reg <= (len_reg == '0) ? ST_EMIT : ST_TWAIT;
                        k_reg     <= '0;
                    end
                    else
                    begin
                        a_sym_reg <= seq_a_mem[i_reg[AW-1:0]];
                        i_reg     <= i_reg + ACW'(1);
                        j_reg     <= '0;
                        state_reg <= ST_FILL;
                    end
                end
                ST_TWAIT:
                begin
                    // read of direction and symbol at (i, j) lands next cycle
                    if (i_reg == '0 || j_reg == '0 || pos_reg == '0)
                    begin
                        state_reg <= ST_EMIT;
                        k_reg     <= '0;
                    end
                    else
                    begin
                        state_reg <= ST_TRACE;
                    end
                end
                ST_TRACE:
                begin
                    if (dir_rd_reg == DIR_DIAG)
                    begin
                        pos_reg <= pos_reg - PCW'(1);
                        i_reg   <= i_reg - ACW'(1);
                        j_reg   <= j_reg - BCW'(1);
                    end
                    else if (dir_rd_reg == DIR_UP)
                    begin
                        i_reg <= i_reg - ACW'(1);
                    end
                    else
                    begin
                        j_reg <= j_reg - BCW'(1);
                    end
                    state_reg <= ST_TWAIT;
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        o_valid_reg  <= 1'b1;
                        o_empty_reg  <= (len_reg == '0);
                        o_symbol_reg <= (len_reg == '0) ? 8'd0 : path_rd_reg;
                        o_length_reg <= 6'(len_reg);
                        o_last_reg   <= (len_reg == '0) ||
                                        (k_reg + PCW'(1) == len_reg);
                        i_reg        <= '0;
                        if ((len_reg == '0) || (k_reg + PCW'(1) == len_reg))
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            k_reg <= k_reg + PCW'(1);
                        end
                    end
                    else if (i_reg != '1)
                    begin
                        // wait so the path read of k is registered
                        i_reg <= '1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = o_valid_reg;
    assign o_symbol = o_symbol_reg;
    assign o_length = o_length_reg;
    assign o_last   = o_last_reg;
    assign o_empty  = o_empty_reg;

    `LCS_ASSERT_IMP(a_empty_len, clk, rst_n, o_valid_reg && o_empty_reg,
        o_last_reg && o_length_reg == 6'd0, "empty beat not last or length nonzero")
    `LCS_ASSERT_IMP(a_len_cap, clk, rst_n, 1'b1, len_reg <= SW'(MINAB), "length above capacity")
    `LCS_ASSERT_NEXT(a_hold, clk, rst_n, o_valid_reg && !o_ready,
        o_valid_reg && $stable(o_symbol_reg) && $stable(o_last_reg) && $stable(o_length_reg),
        "result beat changed")
endmodule

// ===== rtl/lcs_dp_traceback_top.sv =====
// ----------------------------------------------------------------------------
// lcs dp traceback top
// longest common subsequence with direction table and traceback
// ----------------------------------------------------------------------------
// channel  dir  tdata                      tuser    tlast
// s_axis   in   [1:0] action [9:2] symbol  -        -
// m_axis   out  [7:0] symbol [13:8] length empty    last
//
// a compute fills the score table row by row, one cell per cycle within a row,
// then traces back one step at a time from (count_a, count_b), then emits one
// beat per lcs symbol, or a single empty beat when the length is zero
// rst_n clears both counts and all control; stored symbols need no reset
// a 4-entry command queue lets loads arrive while the back end works;
// the output register holds a beat while m_axis_tready is low
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lcs_dp_traceback_top
    import lcs_pkg::*;
#(
    parameter int MAX_A = 32,
    parameter int MAX_B = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // action[1:0], symbol[9:2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_symbol[7:0], lcs_length[13:8]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // empty_res
);
    lcs_cmd_t   in_cmd;
    lcs_cmd_t   q_cmd;
    logic       q_valid;
    logic       q_ready;
    logic [7:0] o_symbol;
    logic [5:0] o_length;

    assign in_cmd.action = s_axis_tdata[1:0];
    assign in_cmd.symbol = s_axis_tdata[9:2];

    // front: accept and queue, nop actions dropped here
    lcs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (in_cmd),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    // back: sequence store, fill, traceback, result register
    lcs_back #(
        .MAX_A (MAX_A),
        .MAX_B (MAX_B)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .o_valid  (m_axis_tvalid),
        .o_ready  (m_axis_tready),
        .o_symbol (o_symbol),
        .o_length (o_length),
        .o_last   (m_axis_tlast),
        .o_empty  (m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, o_length, o_symbol};
endmodule
